[rtl/iti_pkg.sv]
// ----------------------------------------------------------------------------
// iti_pkg: shared types and constants of the inverse table interpolator
// Holds table geometry, command and status codes, and the back-end states.
// ----------------------------------------------------------------------------
package iti_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DATA_W      = 32;
  localparam int MAG_W       = DATA_W + 1;
  localparam int BIT_W       = $clog2(MAG_W);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_INTERP   = 2'd0,
    ST_CLAMP    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_WRITE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_FINAL,
    CMD_QUERY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  x;
    logic [DATA_W-1:0]  y;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } cmd_hs_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_PREP,
    S_ACC,
    S_RED,
    S_FIN,
    S_EMIT
  } back_state_e;

endpackage

[rtl/inverse_table_interpolator.sv]
// ----------------------------------------------------------------------------
// inverse_table_interpolator: inverse linear interpolation over a point table
// Loads (x, y) points and answers target-y queries with interpolated x.
// ----------------------------------------------------------------------------
//  channel | handshake      | payload
//  input   | push / full    | op, entry_index, point_x, point_y, is_final
//  result  | empty / pop    | x_result, status
//  config  | cfg_we_i       | cfg_data_i (entries_used)
//
// A write goes from acceptance straight to the result stage; a final query
// reads only the last used entry. A query walks the table entry by entry on
// the single memory read port, then runs the serial multiply-divide.
// Reset clears control state; table contents are undefined until written.
// The input queue holds two transactions, so input and result stall apart.
// ----------------------------------------------------------------------------
module inverse_table_interpolator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              op_i,
  input  logic [iti_pkg::IDX_W-1:0]         entry_index_i,
  input  logic signed [iti_pkg::DATA_W-1:0] point_x_i,
  input  logic signed [iti_pkg::DATA_W-1:0] point_y_i,
  input  logic                              is_final_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [iti_pkg::DATA_W-1:0] x_result_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_we_i,
  input  logic [iti_pkg::CNT_W-1:0]         cfg_data_i
);
  import iti_pkg::*;

  cmd_t    cmd;
  cmd_hs_t hs;

  // Front end: accept and classify
  iti_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .is_final_i    (is_final_i),
    .cmd_o         (cmd),
    .cmd_valid_o   (hs.valid),
    .cmd_pop_i     (hs.pop)
  );

  // Back end: table, search and interpolation
  iti_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .cmd_valid_i (hs.valid),
    .cmd_pop_o   (hs.pop),
    .empty       (empty),
    .pop         (pop),
    .x_result_o  (x_result_o),
    .status_o    (status_o)
  );

endmodule

[rtl/iti_front.sv]
// ----------------------------------------------------------------------------
// iti_front: input side of the interpolator
// Accepts transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module iti_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          op_i,
  input  logic [iti_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [iti_pkg::DATA_W-1:0]    point_x_i,
  input  logic [iti_pkg::DATA_W-1:0]    point_y_i,
  input  logic                          is_final_i,
  output iti_pkg::cmd_t                 cmd_o,
  output logic                          cmd_valid_o,
  input  logic                          cmd_pop_i
);
  import iti_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;
  cmd_t       cls;

  // Classify the incoming transaction
  always_comb begin
    cls.idx = entry_index_i;
    cls.x   = point_x_i;
    cls.y   = point_y_i;
    if (op_i == OP_WRITE) begin
      cls.kind = CMD_WRITE;
    end else if (is_final_i) begin
      cls.kind = CMD_FINAL;
    end else begin
      cls.kind = CMD_QUERY;
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  // Store queued commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

[rtl/iti_back.sv]
// ----------------------------------------------------------------------------
// iti_back: table store, search and interpolation engine
// Walks the table one entry at a time, then forms x0 + dx*num/den with
// a serial multiply-divide that consumes one bit of |dx| per ACC/RED pass.
// ----------------------------------------------------------------------------
module iti_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iti_pkg::CNT_W-1:0]     cfg_data_i,
  input  iti_pkg::cmd_t                 cmd_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [iti_pkg::DATA_W-1:0] x_result_o,
  output logic [1:0]                    status_o
);
  import iti_pkg::*;

  back_state_e state_q, state_d;

  logic [2*DATA_W-1:0] mem_q [TABLE_DEPTH];
  logic [2*DATA_W-1:0] rd_q;
  logic [DATA_W-1:0]   rd_x, rd_y;
  logic                mem_we;

  logic [CNT_W-1:0]  used_q, n_eff;
  logic [CNT_W-1:0]  j_q;
  logic              fin_q;
  logic [DATA_W-1:0] py_q, x0_q, y0_q, x1_q, y1_q;
  logic              hit;

  logic              neg_q;
  logic [MAG_W-1:0]  mag_q, q_q;
  logic [DATA_W-1:0] num_q, den_q, r_q;
  logic [MAG_W-1:0]  den2_q;
  logic [DATA_W+1:0] t_q;
  logic [BIT_W-1:0]  bit_q;

  logic [MAG_W-1:0]  dx;
  logic [DATA_W+1:0] t_m1, t_m2;
  logic [MAG_W-1:0]  sum;

  logic [DATA_W-1:0] res_x_q;
  status_e           res_st_q;
  logic              out_valid_q, out_free, out_load;
  logic [DATA_W-1:0] out_x_q;
  status_e           out_st_q;

  // Clamp the configured length into 1..TABLE_DEPTH
  always_comb begin
    if (used_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (used_q > CNT_W'(TABLE_DEPTH)) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = used_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= CNT_W'(TABLE_DEPTH);
    end else if (cfg_we_i) begin
      used_q <= cfg_data_i;
    end
  end

  // Table memory, one write and one registered read port
  assign rd_x = rd_q[2*DATA_W-1:DATA_W];
  assign rd_y = rd_q[DATA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cmd_i.idx] <= {cmd_i.x, cmd_i.y};
    end
    rd_q <= mem_q[j_q[IDX_W-1:0]];
  end

  assign hit      = $signed(py_q) < $signed(rd_y);
  assign out_free = !out_valid_q || pop;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.kind == CMD_WRITE) ? S_EMIT : S_RD;
        end
      end
      S_RD:  state_d = S_CMP;
      S_CMP: begin
        if (fin_q) begin
          state_d = S_EMIT;
        end else if (hit) begin
          state_d = (j_q == '0) ? S_EMIT : S_PREP;
        end else if (j_q + CNT_W'(1) == n_eff) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_RD;
        end
      end
      S_PREP: state_d = S_ACC;
      S_ACC:  state_d = S_RED;
      S_RED:  state_d = (bit_q == '0) ? S_FIN : S_ACC;
      S_FIN:  state_d = S_EMIT;
      S_EMIT: state_d = out_free ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        mem_we    = cmd_valid_i && (cmd_i.kind == CMD_WRITE);
      end
      S_EMIT:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath arithmetic
  assign dx   = {x1_q[DATA_W-1], x1_q} - {x0_q[DATA_W-1], x0_q};
  assign t_m1 = t_q - {2'b00, den_q};
  assign t_m2 = t_q - {1'b0, den2_q};
  assign sum  = neg_q ? ({x0_q[DATA_W-1], x0_q} - q_q) : ({x0_q[DATA_W-1], x0_q} + q_q);

  // Search, prepare and serial multiply-divide registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        py_q  <= cmd_i.y;
        fin_q <= (cmd_i.kind == CMD_FINAL);
        j_q   <= (cmd_i.kind == CMD_FINAL) ? (n_eff - CNT_W'(1)) : '0;
        res_x_q  <= '0;
        res_st_q <= ST_WRITE;
      end
      S_CMP: begin
        if (fin_q) begin
          res_x_q  <= rd_x;
          res_st_q <= ST_INTERP;
        end else if (hit) begin
          x1_q     <= rd_x;
          y1_q     <= rd_y;
          res_x_q  <= rd_x;
          res_st_q <= ST_CLAMP;
        end else begin
          x0_q     <= rd_x;
          y0_q     <= rd_y;
          j_q      <= j_q + CNT_W'(1);
          res_x_q  <= '0;
          res_st_q <= ST_NOTFOUND;
        end
      end
      S_PREP: begin
        neg_q  <= dx[MAG_W-1];
        mag_q  <= dx[MAG_W-1] ? (MAG_W'(0) - dx) : dx;
        num_q  <= py_q - y0_q;
        den_q  <= y1_q - y0_q;
        den2_q <= {y1_q - y0_q, 1'b0};
        r_q    <= '0;
        q_q    <= '0;
        bit_q  <= BIT_W'(MAG_W - 1);
      end
      S_ACC: begin
        t_q <= {1'b0, r_q, 1'b0} + (mag_q[bit_q] ? {2'b00, num_q} : '0);
        q_q <= {q_q[MAG_W-2:0], 1'b0};
      end
      S_RED: begin
        if (!t_m2[DATA_W+1]) begin
          r_q <= t_m2[DATA_W-1:0];
          q_q <= q_q + MAG_W'(2);
        end else if (!t_m1[DATA_W+1]) begin
          r_q <= t_m1[DATA_W-1:0];
          q_q <= q_q + MAG_W'(1);
        end else begin
          r_q <= t_q[DATA_W-1:0];
        end
        bit_q <= bit_q - BIT_W'(1);
      end
      S_FIN: begin
        res_x_q  <= sum[DATA_W-1:0];
        res_st_q <= ST_INTERP;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q  <= res_x_q;
      out_st_q <= res_st_q;
    end
  end

  assign empty      = !out_valid_q;
  assign x_result_o = out_x_q;
  assign status_o   = out_st_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == S_IDLE) else $error("command taken while busy");
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC || state_q == S_RED) |-> den_q != '0)
    else $error("zero divisor in interpolation");
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> q_q <= mag_q) else $error("quotient exceeds span");
  a_j_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> j_q < n_eff) else $error("search beyond used entries");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || pop)) else $error("result overwritten");
`endif

endmodule

[tb/inverse_table_interpolator_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverse_table_interpolator_checker: result predictor and scoreboard
// Watches the input, result and register channels, keeps a shadow of the point
// table and the length register, and compares every result in order.
// ----------------------------------------------------------------------------
module inverse_table_interpolator_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  input  logic                              full,
  input  logic                              op_i,
  input  logic [iti_pkg::IDX_W-1:0]         entry_index_i,
  input  logic signed [iti_pkg::DATA_W-1:0] point_x_i,
  input  logic signed [iti_pkg::DATA_W-1:0] point_y_i,
  input  logic                              is_final_i,
  input  logic                              empty,
  input  logic                              pop,
  input  logic signed [iti_pkg::DATA_W-1:0] x_result_o,
  input  logic [1:0]                        status_o,
  input  logic                              cfg_we_i,
  input  logic [iti_pkg::CNT_W-1:0]         cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                answers_o
);
  import iti_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    status_e                  status;
  } answer_t;

  logic signed [DATA_W-1:0] shadow_x [TABLE_DEPTH];
  logic signed [DATA_W-1:0] shadow_y [TABLE_DEPTH];
  logic [CNT_W-1:0]         used_reg;
  answer_t                  answer_q [$];

  // Interpolate x between two points, quotient magnitude truncated toward zero
  function automatic logic signed [DATA_W-1:0] interp_x(longint x0, longint y0,
                                                        longint x1, longint y1,
                                                        longint yp);
    longint       dx;
    longint       q;
    logic [63:0]  mag;
    logic [63:0]  num;
    logic [63:0]  den;
    logic [127:0] prod;
    longint       r;
    dx   = x1 - x0;
    mag  = (dx < 0) ? -dx : dx;
    num  = yp - y0;
    den  = y1 - y0;
    prod = {64'd0, mag} * {64'd0, num};
    prod = prod / {64'd0, den};
    q    = longint'(prod[63:0]);
    r    = (dx < 0) ? x0 - q : x0 + q;
    return r[DATA_W-1:0];
  endfunction

  // Answer a query against the shadow table
  function automatic answer_t lookup(logic signed [DATA_W-1:0] target, logic fin);
    answer_t a;
    int      n;
    int      j;
    n = (used_reg == 0) ? 1 : (used_reg > TABLE_DEPTH) ? TABLE_DEPTH : used_reg;
    if (fin) begin
      a.x = shadow_x[n-1];
      a.status = ST_INTERP;
      return a;
    end
    j = 0;
    while (j < n && !(target < shadow_y[j])) j++;
    if (j == n) begin
      a.x = '0;
      a.status = ST_NOTFOUND;
    end else if (j == 0) begin
      a.x = shadow_x[0];
      a.status = ST_CLAMP;
    end else begin
      a.x = interp_x(shadow_x[j-1], shadow_y[j-1], shadow_x[j], shadow_y[j], target);
      a.status = ST_INTERP;
    end
    return a;
  endfunction

  assign pending_o = answer_q.size();

  // Track register, table and the expected answers
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t a;
    answer_t got;
    if (!rst_ni) begin
      used_reg = TABLE_DEPTH;
      answer_q.delete();
      fail_count_o = 0;
      answers_o = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        shadow_x[i] = '0;
        shadow_y[i] = '0;
      end
    end else begin
      if (cfg_we_i) used_reg = cfg_data_i;
      if (push && !full) begin
        if (op_i == OP_WRITE) begin
          shadow_x[entry_index_i] = point_x_i;
          shadow_y[entry_index_i] = point_y_i;
          a.x = '0;
          a.status = ST_WRITE;
        end else begin
          a = lookup(point_y_i, is_final_i);
        end
        answer_q.push_back(a);
      end
      if (pop && !empty) begin
        answers_o++;
        got.x = x_result_o;
        got.status = status_e'(status_o);
        if (answer_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result x=%0d status=%0d", $realtime, got.x,
                     got.status);
        end else begin
          a = answer_q.pop_front();
          if (got.x !== a.x || got.status !== a.status) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch x exp %0d got %0d, status exp %0d got %0d",
                       $realtime, a.x, got.x, a.status, status_o);
          end
        end
      end
    end
  end

endmodule

[tb/inverse_table_interpolator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// inverse_table_interpolator_tb: stimulus and verdict for the interpolator
// Loads point tables, sweeps the length register through its extremes, and
// sends directed then random writes and queries with random idling both ways.
// ----------------------------------------------------------------------------
module inverse_table_interpolator_tb;
  import iti_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_GOAL   = 550;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     push = 1'b0;
  logic                     full;
  logic                     op_i = OP_WRITE;
  logic [IDX_W-1:0]         entry_index_i = '0;
  logic signed [DATA_W-1:0] point_x_i = '0;
  logic signed [DATA_W-1:0] point_y_i = '0;
  logic                     is_final_i = 1'b0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic signed [DATA_W-1:0] x_result_o;
  logic [1:0]               status_o;
  logic                     cfg_we_i = 1'b0;
  logic [CNT_W-1:0]         cfg_data_i = '0;

  int  fail_count;
  int  pending;
  int  answers;
  int  cycles = 0;
  int  items = 0;
  int  pop_stall = 0;
  bit  busy_mode = 1'b0;
  longint shadow_y [TABLE_DEPTH];
  int  used_n = TABLE_DEPTH;

  inverse_table_interpolator dut (
    .clk_i, .rst_ni, .push, .full, .op_i, .entry_index_i, .point_x_i, .point_y_i,
    .is_final_i, .empty, .pop, .x_result_o, .status_o, .cfg_we_i, .cfg_data_i
  );

  inverse_table_interpolator_checker checker_i (
    .clk_i, .rst_ni, .push, .full, .op_i, .entry_index_i, .point_x_i, .point_y_i,
    .is_final_i, .empty, .pop, .x_result_o, .status_o, .cfg_we_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .answers_o(answers)
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("inverse_table_interpolator_tb: errors");
      $finish;
    end
  end

  // Idle length: mostly none or short, a few long; none in busy stretches
  function automatic int gap_len();
    int r;
    if (busy_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drain results with random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_stall > 0) begin
      pop_stall--;
      pop <= 1'b0;
    end else begin
      if (pop && !empty) pop_stall = gap_len();
      pop <= (pop_stall == 0);
    end
  end

  // Push one transaction, then idle for a random gap
  task automatic send(logic op, int idx, longint x, longint y, logic fin);
    int gap;
    push          <= 1'b1;
    op_i          <= op;
    entry_index_i <= idx[IDX_W-1:0];
    point_x_i     <= x[DATA_W-1:0];
    point_y_i     <= y[DATA_W-1:0];
    is_final_i    <= fin;
    do @(posedge clk_i); while (full);
    items++;
    if (op == OP_WRITE) shadow_y[idx] = longint'($signed(y[DATA_W-1:0]));
    gap = gap_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write the length register once the block has gone idle
  task automatic set_used(int value);
    push <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    used_n = (value == 0) ? 1 : (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
  endtask

  // Rising y: spread over the whole range, or a tight random run
  task automatic load_table(int count, bit wide);
    longint base;
    longint step;
    base = $urandom_range(0, 32'hFFFF_0000) - 64'sd2147483648;
    step = $urandom_range(1, 800);
    for (int i = 0; i < count; i++) begin
      if (wide)
        send(OP_WRITE, i, $signed($urandom),
             -64'sd2147483648 + i * 67108864 + $urandom_range(0, 67108863), 1'b0);
      else
        send(OP_WRITE, i, $signed($urandom), base + i * step, 1'b0);
    end
  endtask

  // Pick a target near the live part of the table
  function automatic longint pick_target();
    int r;
    int j;
    r = $urandom_range(0, 99);
    if (r < 10) return longint'($signed($urandom));
    if (r < 20) return shadow_y[0] - $urandom_range(0, 3);
    if (r < 30) return shadow_y[used_n-1] + $urandom_range(0, 3);
    j = $urandom_range(0, used_n - 1);
    if (j == 0 || shadow_y[j] <= shadow_y[j-1]) return shadow_y[j];
    return shadow_y[j-1] + longint'($urandom) % (shadow_y[j] - shadow_y[j-1]);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  initial begin
    int n;
    int r;
    int j;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full-range table with x swinging between the extremes
    busy_mode = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      send(OP_WRITE, i, (i % 2 == 0) ? 64'sd2147483647 : -64'sd2147483648,
           (i == TABLE_DEPTH - 1) ? 64'sd2147483647 : -64'sd2147483647 + i * 68174084,
           1'b0);
    busy_mode = 1'b0;
    send(OP_QUERY, 0, 0, -64'sd2147483648, 1'b0);   // below first entry
    send(OP_QUERY, 0, 0, shadow_y[0], 1'b0);        // exactly on first entry
    send(OP_QUERY, 0, 0, shadow_y[1] - 1, 1'b0);    // just under second entry
    send(OP_QUERY, 63, -1, 0, 1'b0);
    send(OP_QUERY, 0, 0, shadow_y[40] + 34087042, 1'b0);
    send(OP_QUERY, 0, 0, 64'sd2147483647, 1'b0);    // nothing above target
    send(OP_QUERY, 0, 0, 0, 1'b1);                  // final query
    send(OP_WRITE, 63, -64'sd2147483648, 64'sd2147483647, 1'b1);
    send(OP_QUERY, 0, 0, 0, 1'b1);
    send(OP_QUERY, 0, 0, 64'sd2147483646, 1'b0);
    set_used(1);
    send(OP_QUERY, 0, 0, 0, 1'b1);
    send(OP_QUERY, 0, 0, -64'sd2147483648, 1'b0);
    send(OP_QUERY, 0, 0, shadow_y[0], 1'b0);
    set_used(0);
    send(OP_QUERY, 0, 0, 0, 1'b1);
    send(OP_QUERY, 0, 0, shadow_y[0] - 1, 1'b0);
    set_used(127);
    send(OP_QUERY, 0, 0, 0, 1'b1);
    send(OP_QUERY, 0, 0, shadow_y[62], 1'b0);
    set_used(2);
    send(OP_WRITE, 0, 64'sd2147483647, -64'sd2147483648, 1'b0);
    send(OP_WRITE, 1, -64'sd2147483648, 64'sd2147483647, 1'b0);
    send(OP_QUERY, 0, 0, 0, 1'b0);
    send(OP_QUERY, 0, 0, 64'sd2147483646, 1'b0);

    // Random phases: new length, fresh rising table, then mixed traffic
    while (items < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      n = (r < 55) ? $urandom_range(1, 8) : (r < 70) ? 64 :
          (r < 75) ? 0 : (r < 80) ? $urandom_range(65, 127) : $urandom_range(9, 63);
      set_used(n);
      busy_mode = ($urandom_range(0, 3) == 0);
      load_table(used_n, $urandom_range(0, 1));
      repeat ($urandom_range(10, 30)) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send(OP_QUERY, $urandom_range(0, 63), $signed($urandom), pick_target(), 1'b0);
        end else if (r < 75) begin
          send(OP_QUERY, $urandom_range(0, 63), $signed($urandom), pick_target(), 1'b1);
        end else if (r < 90) begin
          // rewrite a live entry, nudging its y by -2 to +2 (order is not checked)
          j = $urandom_range(0, used_n - 1);
          send(OP_WRITE, j, $signed($urandom),
               clip32(shadow_y[j] + $signed($urandom_range(0, 4)) - 2), 1'b0);
        end else begin
          send(OP_WRITE, $urandom_range(0, 63), $signed($urandom),
               longint'($signed($urandom)), 1'b0);
        end
      end
    end

    // Let the last results drain
    push <= 1'b0;
    busy_mode = 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d transactions, checked %0d results", items, answers);
    $display("Table lengths 0 to 127, full-range and tight tables, final queries");
    if (fail_count == 0 && pending == 0) begin
      $display("inverse_table_interpolator_tb: clean");
    end else begin
      $display("inverse_table_interpolator_tb: errors");
    end
    $finish;
  end

endmodule
